// ===== hdl/sdorc_pkg.sv =====
// Shared types, codes and constants of the parameter request/retry controller.
package sdorc_pkg;

   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [3:0] FRAME_BASE_LEN = 4'd7;
   localparam logic [2:0] MAX_WRITE_LEN  = 3'd4;

   localparam logic [7:0]  TIMEOUT_LIMIT_RESET = 8'd3;
   localparam logic [7:0]  BUSY_LIMIT_RESET    = 8'd3;
   localparam logic [31:0] RESP_TIMEOUT_RESET  = 32'd400;

   typedef enum logic [2:0] {
      CMD_READ_REQ   = 3'd0,
      CMD_WRITE_REQ  = 3'd1,
      CMD_READ_RESP  = 3'd2,
      CMD_WRITE_RESP = 3'd3,
      CMD_OTHER_RESP = 3'd4,
      CMD_TIME       = 3'd5,
      CMD_RESET      = 3'd6,
      CMD_FETCH      = 3'd7
   } cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_WAIT    = 6'b000010,
      ST_RETRY   = 6'b000100,
      ST_DONE    = 6'b001000,
      ST_ERROR   = 6'b010000,
      ST_TIMEOUT = 6'b100000
   } state_type;

   localparam logic [2:0] CODE_IDLE    = 3'd0;
   localparam logic [2:0] CODE_WAIT    = 3'd1;
   localparam logic [2:0] CODE_RETRY   = 3'd2;
   localparam logic [2:0] CODE_DONE    = 3'd3;
   localparam logic [2:0] CODE_ERROR   = 3'd4;
   localparam logic [2:0] CODE_TIMEOUT = 3'd5;

   typedef enum logic [1:0] {
      REG_TIMEOUT_LIMIT = 2'd0,
      REG_BUSY_LIMIT    = 2'd1,
      REG_RESP_TIMEOUT  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] obj_index;
      logic [7:0]  obj_sub_index;
      logic [31:0] data_word;
      logic [2:0]  payload_len;
      logic        lock_granted;
      logic        send_accepted;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  transfer_state;
      logic        frame_valid;
      logic        frame_is_write;
      logic [3:0]  frame_len;
      logic [15:0] frame_index;
      logic [7:0]  frame_sub_index;
      logic [31:0] frame_data;
      logic [31:0] obj_value;
      logic [2:0]  rx_payload_len;
      logic        lock_held;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  timeout_retry_limit;
      logic [7:0]  busy_retry_limit;
      logic [31:0] response_timeout;
   } cfg_type;

   function automatic logic [2:0] state_code(state_type st);
      logic [2:0] code;
      unique case (st)
         ST_IDLE:    code = CODE_IDLE;
         ST_WAIT:    code = CODE_WAIT;
         ST_RETRY:   code = CODE_RETRY;
         ST_DONE:    code = CODE_DONE;
         ST_ERROR:   code = CODE_ERROR;
         ST_TIMEOUT: code = CODE_TIMEOUT;
         default:    code = CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ===== hdl/sdorc_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct.
interface sdorc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/sdorc_csr.sv =====
// APB-style configuration registers: retry limits and response timeout.
module sdorc_csr
   import sdorc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_TIMEOUT_LIMIT: cfg_in.timeout_retry_limit = csr_pwdata[7:0];
            REG_BUSY_LIMIT:    cfg_in.busy_retry_limit    = csr_pwdata[7:0];
            REG_RESP_TIMEOUT:  cfg_in.response_timeout    = csr_pwdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_TIMEOUT_LIMIT: csr_prdata = {24'd0, cfg_ff.timeout_retry_limit};
         REG_BUSY_LIMIT:    csr_prdata = {24'd0, cfg_ff.busy_retry_limit};
         REG_RESP_TIMEOUT:  csr_prdata = cfg_ff.response_timeout;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_retry_limit <= TIMEOUT_LIMIT_RESET;
         cfg_ff.busy_retry_limit    <= BUSY_LIMIT_RESET;
         cfg_ff.response_timeout    <= RESP_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/sdorc_engine.sv =====
// Transfer state, retry counters, lock and timer, and the per-item update logic.
module sdorc_engine
   import sdorc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   state_type   state_ff, state_in;
   logic [7:0]  tmo_retries_ff, tmo_retries_in;
   logic [7:0]  busy_retries_ff, busy_retries_in;
   logic        lock_ff, lock_in;
   logic        timer_ff, timer_in;
   logic [31:0] sent_time_ff, sent_time_in;
   logic [31:0] cur_time_ff, cur_time_in;
   logic [15:0] rd_idx_ff, rd_idx_in;
   logic [7:0]  rd_sub_ff, rd_sub_in;
   logic [15:0] wr_idx_ff, wr_idx_in;
   logic [7:0]  wr_sub_ff, wr_sub_in;
   logic [31:0] rx_value_ff, rx_value_in;
   logic [2:0]  rx_len_ff, rx_len_in;

   cmd_type     cmd;
   logic        open_state;
   logic        can_send;
   logic        is_write;
   logic [2:0]  write_len;
   logic [8:0]  busy_next;
   logic [31:0] deadline;
   logic        sent;

   assign cmd        = cmd_type'(item.cmd);
   assign open_state = (state_ff == ST_WAIT) || (state_ff == ST_RETRY);
   assign can_send   = (state_ff == ST_IDLE) || (state_ff == ST_RETRY);
   assign is_write   = (cmd == CMD_WRITE_REQ);
   assign write_len  = (item.payload_len > MAX_WRITE_LEN) ? MAX_WRITE_LEN : item.payload_len;
   assign busy_next  = {1'b0, busy_retries_ff} + 9'd1;
   assign deadline   = sent_time_ff + cfg.response_timeout;

   always_comb begin
      state_in        = state_ff;
      tmo_retries_in  = tmo_retries_ff;
      busy_retries_in = busy_retries_ff;
      lock_in         = lock_ff;
      timer_in        = timer_ff;
      sent_time_in    = sent_time_ff;
      cur_time_in     = cur_time_ff;
      rd_idx_in       = rd_idx_ff;
      rd_sub_in       = rd_sub_ff;
      wr_idx_in       = wr_idx_ff;
      wr_sub_in       = wr_sub_ff;
      rx_value_in     = rx_value_ff;
      rx_len_in       = rx_len_ff;
      sent            = 1'b0;

      unique case (cmd)
         CMD_READ_REQ, CMD_WRITE_REQ: begin
            if (can_send) begin
               if (is_write) begin
                  wr_idx_in = item.obj_index;
                  wr_sub_in = item.obj_sub_index;
               end else begin
                  rd_idx_in = item.obj_index;
                  rd_sub_in = item.obj_sub_index;
               end
               lock_in = item.lock_granted;
               if (item.lock_granted) begin
                  if (item.send_accepted) begin
                     state_in        = ST_WAIT;
                     busy_retries_in = 8'd0;
                     sent_time_in    = cur_time_ff;
                     timer_in        = 1'b1;
                     sent            = 1'b1;
                  end else begin
                     // refused send: free the link and count the attempt
                     lock_in  = 1'b0;
                     state_in = (busy_next > {1'b0, cfg.busy_retry_limit}) ? ST_ERROR
                                                                           : ST_RETRY;
                     busy_retries_in = busy_next[8] ? 8'hFF : busy_next[7:0];
                  end
               end
            end
         end
         CMD_READ_RESP: begin
            if (item.obj_index == rd_idx_ff && item.obj_sub_index == rd_sub_ff
                && open_state) begin
               rx_len_in   = item.payload_len;
               rx_value_in = item.data_word;
               timer_in    = 1'b0;
               state_in    = ST_DONE;
               lock_in     = 1'b0;
            end else begin
               state_in = ST_ERROR;
            end
         end
         CMD_WRITE_RESP: begin
            if (item.obj_index == wr_idx_ff && item.obj_sub_index == wr_sub_ff
                && open_state) begin
               state_in = ST_DONE;
               lock_in  = 1'b0;
               timer_in = 1'b0;
            end else begin
               state_in = ST_ERROR;
            end
         end
         CMD_OTHER_RESP: begin
            state_in = ST_ERROR;
         end
         CMD_TIME: begin
            cur_time_in = item.now_time;
            if (timer_ff && (deadline < item.now_time)) begin
               timer_in = 1'b0;
               if (tmo_retries_ff < cfg.timeout_retry_limit) begin
                  state_in       = ST_RETRY;
                  tmo_retries_in = tmo_retries_ff + 8'd1;
                  lock_in        = 1'b0;
               end else begin
                  // give up: lock stays held
                  state_in       = ST_TIMEOUT;
                  tmo_retries_in = 8'd0;
               end
            end
         end
         CMD_RESET: begin
            // timer is left running
            state_in        = ST_IDLE;
            tmo_retries_in  = 8'd0;
            busy_retries_in = 8'd0;
            lock_in         = 1'b0;
         end
         CMD_FETCH: begin
            if (state_ff == ST_DONE) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_comb begin
      result.transfer_state  = state_code(state_in);
      result.frame_valid     = sent;
      result.frame_is_write  = sent && is_write;
      result.frame_len       = '0;
      result.frame_index     = '0;
      result.frame_sub_index = '0;
      result.frame_data      = '0;
      if (sent) begin
         result.frame_len       = is_write ? FRAME_BASE_LEN + {1'b0, write_len}
                                           : FRAME_BASE_LEN;
         result.frame_index     = item.obj_index;
         result.frame_sub_index = item.obj_sub_index;
         result.frame_data      = is_write ? item.data_word : 32'd0;
      end
      result.obj_value      = rx_value_in;
      result.rx_payload_len = rx_len_in;
      result.lock_held      = lock_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tmo_retries_ff  <= '0;
         busy_retries_ff <= '0;
         lock_ff         <= 1'b0;
         timer_ff        <= 1'b0;
         sent_time_ff    <= '0;
         cur_time_ff     <= '0;
         rd_idx_ff       <= '0;
         rd_sub_ff       <= '0;
         wr_idx_ff       <= '0;
         wr_sub_ff       <= '0;
         rx_value_ff     <= '0;
         rx_len_ff       <= '0;
      end else if (advance) begin
         state_ff        <= state_in;
         tmo_retries_ff  <= tmo_retries_in;
         busy_retries_ff <= busy_retries_in;
         lock_ff         <= lock_in;
         timer_ff        <= timer_in;
         sent_time_ff    <= sent_time_in;
         cur_time_ff     <= cur_time_in;
         rd_idx_ff       <= rd_idx_in;
         rd_sub_ff       <= rd_sub_in;
         wr_idx_ff       <= wr_idx_in;
         wr_sub_ff       <= wr_sub_in;
         rx_value_ff     <= rx_value_in;
         rx_len_ff       <= rx_len_in;
      end
   end

   a_wait_busy_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> busy_retries_ff == 8'd0)
      else $error("busy retry count non-zero while waiting for a response");

   a_lock_free_at_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !lock_ff)
      else $error("link lock held in idle or done");

   a_sent_starts_timer: assert property (@(posedge clock) disable iff (reset)
      advance && result.frame_valid |=>
         state_ff == ST_WAIT && timer_ff && sent_time_ff == $past(cur_time_ff))
      else $error("sent frame did not start the response timer");

endmodule

// ===== hdl/sdo_request_retry_controller.sv =====
// Top level: input register, transfer engine, result register and configuration port.
// Path: a transferred request is held in the input register, processed by the engine,
//   and its result is loaded into the result register and offered on rsp_ch.
// Throughput: one item per cycle while rsp_ch is ready; the state update is the only loop.
// Backpressure on rsp_ch holds the result register, then the input register.
// Synchronous reset clears the transfer state, counters, lock, timer and both valid flags;
//   configuration returns to timeout limit 3, busy limit 3, response timeout 400.
module sdo_request_retry_controller
   import sdorc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   sdorc_stream_if.sink            req_ch,
   sdorc_stream_if.source          rsp_ch,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type cfg;
   req_type in_item_ff;
   rsp_type out_item_ff;
   rsp_type result;
   logic    in_valid_ff, in_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    advance;
   logic    req_xfer;

   sdorc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdorc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // advance the held item when the result register is free or being emptied
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      priority if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_ch.payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_item_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the parameter request/retry controller.
module tb_top;
   import sdorc_pkg::*;

   localparam int unsigned OpeningRows    = 29;
   localparam int unsigned RandomPerPhase = 200;
   localparam int unsigned BusyBurst      = 256;
   localparam int unsigned WatchdogLimit  = 1000;

   typedef struct {
      cmd_type     cmd;
      logic [15:0] idx;
      logic [7:0]  sub;
      logic [31:0] data;
      logic [2:0]  plen;
      bit          grant;
      bit          accept;
      logic [31:0] now;
      bit          pinned;
      logic [2:0]  st;
      bit          frame;
      bit          lock;
   } opening_row_type;

   logic clock;
   logic reset;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   sdorc_stream_if #(.payload_type(req_type)) req_if ();
   sdorc_stream_if #(.payload_type(rsp_type)) rsp_if ();

   sdo_request_retry_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted controller state and register copy
   cfg_type     csr_shadow;
   logic [2:0]  xfer_st;
   logic [7:0]  tmo_retries;
   logic [7:0]  busy_retries;
   logic        lock_owned;
   logic        timer_armed;
   logic [31:0] send_stamp;
   logic [31:0] time_now;
   logic [15:0] rd_index;
   logic [7:0]  rd_sub;
   logic [15:0] wr_index;
   logic [7:0]  wr_sub;
   logic [31:0] rx_value;
   logic [2:0]  rx_len;
   logic        sent_write;

   rsp_type         status_due[$];
   opening_row_type opening_rows[OpeningRows];
   int unsigned     fault_count;
   int unsigned     quiet_cycles;
   int unsigned     idle_pct;

   always #5 clock = ~clock;

   function automatic rsp_type next_status(req_type it);
      rsp_type     r;
      logic [8:0]  busy_next;
      logic [2:0]  wlen;
      logic [31:0] deadline;
      logic        wr;
      logic        open_st;
      r = '0;
      open_st = (xfer_st == CODE_WAIT) || (xfer_st == CODE_RETRY);
      case (cmd_type'(it.cmd))
         CMD_READ_REQ, CMD_WRITE_REQ: begin
            if (xfer_st == CODE_IDLE || xfer_st == CODE_RETRY) begin
               wr = (it.cmd == CMD_WRITE_REQ);
               wlen = (it.payload_len > MAX_WRITE_LEN) ? MAX_WRITE_LEN : it.payload_len;
               if (wr) begin
                  wr_index = it.obj_index;
                  wr_sub   = it.obj_sub_index;
               end else begin
                  rd_index = it.obj_index;
                  rd_sub   = it.obj_sub_index;
               end
               lock_owned = it.lock_granted;
               if (it.lock_granted && it.send_accepted) begin
                  xfer_st      = CODE_WAIT;
                  busy_retries = '0;
                  send_stamp   = time_now;
                  timer_armed  = 1'b1;
                  sent_write   = wr;
                  r.frame_valid     = 1'b1;
                  r.frame_is_write  = wr;
                  r.frame_len       = wr ? FRAME_BASE_LEN + {1'b0, wlen} : FRAME_BASE_LEN;
                  r.frame_index     = it.obj_index;
                  r.frame_sub_index = it.obj_sub_index;
                  r.frame_data      = wr ? it.data_word : '0;
               end else if (it.lock_granted) begin
                  // refused send: drop the lock and count towards the busy limit
                  lock_owned   = 1'b0;
                  busy_next    = {1'b0, busy_retries} + 9'd1;
                  xfer_st      = (busy_next > {1'b0, csr_shadow.busy_retry_limit}) ?
                                 CODE_ERROR : CODE_RETRY;
                  busy_retries = busy_next[8] ? 8'hFF : busy_next[7:0];
               end
            end
         end
         CMD_READ_RESP: begin
            if (it.obj_index == rd_index && it.obj_sub_index == rd_sub && open_st) begin
               rx_len      = it.payload_len;
               rx_value    = it.data_word;
               timer_armed = 1'b0;
               xfer_st     = CODE_DONE;
               lock_owned  = 1'b0;
            end else begin
               xfer_st = CODE_ERROR;
            end
         end
         CMD_WRITE_RESP: begin
            if (it.obj_index == wr_index && it.obj_sub_index == wr_sub && open_st) begin
               xfer_st     = CODE_DONE;
               lock_owned  = 1'b0;
               timer_armed = 1'b0;
            end else begin
               xfer_st = CODE_ERROR;
            end
         end
         CMD_OTHER_RESP: xfer_st = CODE_ERROR;
         CMD_TIME: begin
            time_now = it.now_time;
            deadline = send_stamp + csr_shadow.response_timeout;
            if (timer_armed && deadline < it.now_time) begin
               if (tmo_retries < csr_shadow.timeout_retry_limit) begin
                  xfer_st     = CODE_RETRY;
                  tmo_retries = tmo_retries + 8'd1;
                  lock_owned  = 1'b0;
               end else begin
                  // give up: keep the lock
                  xfer_st     = CODE_TIMEOUT;
                  tmo_retries = '0;
               end
               timer_armed = 1'b0;
            end
         end
         CMD_RESET: begin
            xfer_st      = CODE_IDLE;
            tmo_retries  = '0;
            busy_retries = '0;
            lock_owned   = 1'b0;
         end
         default: if (xfer_st == CODE_DONE) xfer_st = CODE_IDLE;
      endcase
      r.transfer_state = xfer_st;
      r.obj_value      = rx_value;
      r.rx_payload_len = rx_len;
      r.lock_held      = lock_owned;
      return r;
   endfunction

   function automatic logic [31:0] next_time();
      if (csr_shadow.response_timeout <= 32'd2000)
         return time_now + $urandom_range(0, 2 * csr_shadow.response_timeout + 2);
      return time_now + $urandom;
   endfunction

   // mostly well-formed traffic steered by the predicted state, with some noise
   function automatic req_type random_request();
      req_type     it;
      int unsigned pick;
      it = req_type'({$urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 15) return it;
      case (xfer_st)
         CODE_IDLE, CODE_RETRY: begin
            if (pick < 80) begin
               it.cmd = (pick < 48) ? CMD_READ_REQ : CMD_WRITE_REQ;
               it.lock_granted  = ($urandom_range(0, 99) < 85);
               it.send_accepted = ($urandom_range(0, 99) < 80);
            end else begin
               it.cmd      = CMD_TIME;
               it.now_time = next_time();
            end
         end
         CODE_WAIT: begin
            if (pick < 60) begin
               it.cmd           = sent_write ? CMD_WRITE_RESP : CMD_READ_RESP;
               it.obj_index     = sent_write ? wr_index : rd_index;
               it.obj_sub_index = sent_write ? wr_sub : rd_sub;
               if ($urandom_range(0, 9) == 0) it.obj_sub_index = ~it.obj_sub_index;
            end else begin
               it.cmd      = CMD_TIME;
               it.now_time = next_time();
            end
         end
         CODE_DONE: it.cmd = CMD_FETCH;
         default: begin
            if (pick < 55) begin
               it.cmd = CMD_RESET;
            end else begin
               it.cmd      = CMD_TIME;
               it.now_time = next_time();
            end
         end
      endcase
      return it;
   endfunction

   function automatic opening_row_type mk_row(cmd_type cmd, logic [15:0] idx, logic [7:0] sub,
         logic [31:0] data, logic [2:0] plen, bit grant, bit accept, logic [31:0] now,
         bit pinned, logic [2:0] st, bit frame, bit lock);
      opening_row_type row;
      row = '{cmd, idx, sub, data, plen, grant, accept, now, pinned, st, frame, lock};
      return row;
   endfunction

   // hold the item until its transfer, then book its predicted status
   task automatic send_item(req_type it, bit pinned, logic [2:0] st, bit frame, bit lock);
      bit      taken;
      rsp_type want;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if ($urandom_range(0, 99) < idle_pct) begin
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid   <= 1'b1;
            req_if.payload <= it;
            @(posedge clock);
            while (!req_if.ready) @(posedge clock);
            taken = 1'b1;
         end
      end
      want = next_status(it);
      if (pinned) begin
         want.transfer_state = st;
         want.frame_valid    = frame;
         want.lock_held      = lock;
      end
      status_due.push_back(want);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrWidth'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_TIMEOUT_LIMIT: csr_shadow.timeout_retry_limit = value[7:0];
         REG_BUSY_LIMIT:    csr_shadow.busy_retry_limit    = value[7:0];
         default:           csr_shadow.response_timeout    = value;
      endcase
   endtask

   task automatic set_limits(logic [7:0] tmo_lim, logic [7:0] busy_lim, logic [31:0] resp_tmo);
      drain();
      csr_write(REG_TIMEOUT_LIMIT, {24'd0, tmo_lim});
      csr_write(REG_BUSY_LIMIT, {24'd0, busy_lim});
      csr_write(REG_RESP_TIMEOUT, resp_tmo);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endfunction

   always @(negedge clock) rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);

   always @(posedge clock) begin : status_check
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (status_due.size() == 0) begin
            $error("transfer_state: expected no result, got %0h", got.transfer_state);
            fault_count++;
         end else begin
            want = status_due.pop_front();
            check_field("transfer_state", want.transfer_state, got.transfer_state);
            check_field("frame_valid", want.frame_valid, got.frame_valid);
            check_field("frame_is_write", want.frame_is_write, got.frame_is_write);
            check_field("frame_len", want.frame_len, got.frame_len);
            check_field("frame_index", want.frame_index, got.frame_index);
            check_field("frame_sub_index", want.frame_sub_index, got.frame_sub_index);
            check_field("frame_data", want.frame_data, got.frame_data);
            check_field("obj_value", want.obj_value, got.obj_value);
            check_field("rx_payload_len", want.rx_payload_len, got.rx_payload_len);
            check_field("lock_held", want.lock_held, got.lock_held);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_type it;
      clock          = 1'b0;
      reset          = 1'b1;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      fault_count    = 0;
      quiet_cycles   = 0;
      idle_pct       = 35;

      csr_shadow = '{TIMEOUT_LIMIT_RESET, BUSY_LIMIT_RESET, RESP_TIMEOUT_RESET};
      xfer_st      = CODE_IDLE;
      tmo_retries  = '0;
      busy_retries = '0;
      lock_owned   = 1'b0;
      timer_armed  = 1'b0;
      send_stamp   = '0;
      time_now     = '0;
      rd_index     = '0;
      rd_sub       = '0;
      wr_index     = '0;
      wr_sub       = '0;
      rx_value     = '0;
      rx_len       = '0;
      sent_write   = 1'b0;

      opening_rows[0]  = mk_row(CMD_FETCH, 0, 0, 0, 0, 0, 0, 0, 1, CODE_IDLE, 0, 0);
      opening_rows[1]  = mk_row(CMD_READ_REQ, 16'hFFFF, 8'hFF, 0, 0, 0, 1, 0,
                                1, CODE_IDLE, 0, 0);
      opening_rows[2]  = mk_row(CMD_READ_REQ, 16'hFFFF, 8'hFF, 0, 0, 1, 1, 0,
                                1, CODE_WAIT, 1, 1);
      opening_rows[3]  = mk_row(CMD_READ_RESP, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 4, 0, 0, 0,
                                1, CODE_DONE, 0, 0);
      opening_rows[4]  = mk_row(CMD_FETCH, 0, 0, 0, 0, 0, 0, 0, 1, CODE_IDLE, 0, 0);
      opening_rows[5]  = mk_row(CMD_WRITE_REQ, 0, 0, 32'hFFFF_FFFF, 7, 1, 1, 0,
                                1, CODE_WAIT, 1, 1);
      opening_rows[6]  = mk_row(CMD_WRITE_RESP, 1, 0, 0, 0, 0, 0, 0, 1, CODE_ERROR, 0, 1);
      opening_rows[7]  = mk_row(CMD_TIME, 0, 0, 0, 0, 0, 0, 401, 0, CODE_IDLE, 0, 0);
      for (int i = 8; i < 11; i++)
         opening_rows[i] = mk_row(CMD_WRITE_REQ, 16'h1234, 8'h56, 32'hC3C3_C3C3, 3, 1, 0, 0,
                                  0, CODE_IDLE, 0, 0);
      opening_rows[11] = mk_row(CMD_WRITE_REQ, 16'h1234, 8'h56, 32'hC3C3_C3C3, 3, 1, 0, 0,
                                1, CODE_ERROR, 0, 0);
      opening_rows[12] = mk_row(CMD_RESET, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 7, 1, 1,
                                32'hFFFF_FFFF, 1, CODE_IDLE, 0, 0);
      opening_rows[13] = mk_row(CMD_WRITE_REQ, 16'h1234, 8'h56, 32'hA5A5_A5A5, 0, 1, 1, 0,
                                0, CODE_IDLE, 0, 0);
      opening_rows[14] = mk_row(CMD_WRITE_RESP, 16'h1234, 8'h56, 0, 0, 0, 0, 0,
                                1, CODE_DONE, 0, 0);
      opening_rows[15] = mk_row(CMD_FETCH, 0, 0, 0, 0, 0, 0, 0, 1, CODE_IDLE, 0, 0);
      opening_rows[16] = mk_row(CMD_WRITE_REQ, 16'hFFFF, 8'hFF, 0, 2, 1, 1, 0,
                                0, CODE_IDLE, 0, 0);
      opening_rows[17] = mk_row(CMD_OTHER_RESP, 0, 0, 0, 0, 0, 0, 0, 1, CODE_ERROR, 0, 1);
      opening_rows[18] = mk_row(CMD_TIME, 0, 0, 0, 0, 0, 0, 0, 0, CODE_IDLE, 0, 0);
      opening_rows[19] = mk_row(CMD_TIME, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, CODE_IDLE, 0, 0);
      opening_rows[20] = mk_row(CMD_READ_REQ, 16'h5A5A, 8'hA5, 0, 0, 1, 1, 0,
                                0, CODE_IDLE, 0, 0);
      // deadline wraps past zero
      opening_rows[21] = mk_row(CMD_TIME, 0, 0, 0, 0, 0, 0, 400, 0, CODE_IDLE, 0, 0);
      opening_rows[22] = opening_rows[20];
      opening_rows[23] = mk_row(CMD_TIME, 0, 0, 0, 0, 0, 0, 801, 0, CODE_IDLE, 0, 0);
      opening_rows[24] = opening_rows[20];
      opening_rows[25] = mk_row(CMD_TIME, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
                                1, CODE_TIMEOUT, 0, 1);
      opening_rows[26] = mk_row(CMD_READ_REQ, 16'h5A5A, 8'hA5, 0, 0, 1, 1, 0,
                                1, CODE_TIMEOUT, 0, 1);
      opening_rows[27] = mk_row(CMD_READ_RESP, 16'h5A5A, 8'hA5, 0, 0, 0, 0, 0,
                                1, CODE_ERROR, 0, 1);
      opening_rows[28] = mk_row(CMD_RESET, 0, 0, 0, 0, 0, 0, 0, 1, CODE_IDLE, 0, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i]) begin
         it = '{opening_rows[i].cmd, opening_rows[i].idx, opening_rows[i].sub,
                opening_rows[i].data, opening_rows[i].plen, opening_rows[i].grant,
                opening_rows[i].accept, opening_rows[i].now};
         send_item(it, opening_rows[i].pinned, opening_rows[i].st,
                   opening_rows[i].frame, opening_rows[i].lock);
      end
      repeat (RandomPerPhase) send_item(random_request(), 0, CODE_IDLE, 0, 0);

      set_limits(8'd0, 8'd0, 32'd0);
      repeat (RandomPerPhase) send_item(random_request(), 0, CODE_IDLE, 0, 0);

      // widest limits: the busy counter saturates and errors on the last refusal
      set_limits(8'hFF, 8'hFF, 32'hFFFF_FFFF);
      it = '0;
      it.cmd = CMD_RESET;
      send_item(it, 0, CODE_IDLE, 0, 0);
      repeat (BusyBurst) begin
         it = req_type'({$urandom, $urandom, $urandom});
         it.cmd           = CMD_WRITE_REQ;
         it.lock_granted  = 1'b1;
         it.send_accepted = 1'b0;
         send_item(it, 0, CODE_IDLE, 0, 0);
      end
      repeat (RandomPerPhase) send_item(random_request(), 0, CODE_IDLE, 0, 0);

      set_limits(8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)), $urandom_range(0, 2000));
      repeat (RandomPerPhase) send_item(random_request(), 0, CODE_IDLE, 0, 0);

      set_limits(8'd1, 8'd2, 32'd50);
      idle_pct = 0;
      repeat (RandomPerPhase / 2) send_item(random_request(), 0, CODE_IDLE, 0, 0);
      idle_pct = 35;
      repeat (RandomPerPhase / 2) send_item(random_request(), 0, CODE_IDLE, 0, 0);

      drain();
      repeat (8) @(posedge clock);
      if (fault_count == 0 && status_due.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
